@@ hdl/wave_grid_leapfrog_step_defines.svh @@
// Assertion macros shared by the wave grid RTL.
`ifndef WAVE_GRID_LEAPFROG_STEP_DEFINES_SVH
`define WAVE_GRID_LEAPFROG_STEP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WGL_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WGL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/wgl_pkg.sv @@
// Shared constants, types and helpers for the wave grid engine.
package wgl_pkg;

  localparam int GRID_SIZE = 256;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COORD_W   = $clog2(GRID_SIZE);
  localparam int AMP_W     = 32;
  localparam int GAIN_W    = 17;
  localparam int GAIN_FRAC = 16;
  localparam int LAP_W     = AMP_W + 3;            // N+S+E+W-4C, exact
  localparam int PROD_W    = LAP_W + GAIN_W + 1;   // lap * k, k as signed
  localparam int NEXT_W    = AMP_W + 8;            // t - prev + 2C, exact

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(30583);

  typedef logic signed [AMP_W-1:0] amp_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic [GAIN_W-1:0]       gain_t;

  typedef enum logic [1:0] {
    CMD_WR_CUR  = 2'd0,
    CMD_WR_PREV = 2'd1,
    CMD_RD_CUR  = 2'd2,
    CMD_STEP    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] row;
    logic [7:0] col;
    amp_t       value;
  } req_t;

  typedef struct packed {
    amp_t amplitude;
    logic saturated;
  } rsp_t;

  // Sweep position handed to the stencil pipeline (read-issue stage).
  typedef struct packed {
    logic   valid;
    coord_t col;
    addr_t  ctr_addr;
    logic   interior;
  } stn_ctl_t;

  // Write-back and status from the stencil pipeline.
  typedef struct packed {
    logic  we;
    addr_t addr;
    amp_t  data;
    logic  sat;
    logic  busy;
  } stn_out_t;

  function automatic logic in_grid(logic [7:0] row, logic [7:0] col);
    return (int'(row) < GRID_SIZE) && (int'(col) < GRID_SIZE);
  endfunction

  function automatic logic is_interior(logic [7:0] row, logic [7:0] col);
    return (int'(row) >= 1) && (int'(col) >= 1) &&
           (int'(row) < GRID_SIZE - 1) && (int'(col) < GRID_SIZE - 1);
  endfunction

  function automatic addr_t cell_addr(logic [7:0] row, logic [7:0] col);
    return addr_t'(int'(row) * GRID_SIZE + int'(col));
  endfunction

endpackage

@@ hdl/wgl_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
module wgl_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/wgl_stencil.sv @@
// Five-point stencil pipeline with two line buffers and leapfrog update.
module wgl_stencil (
  input  logic              clk,
  input  logic              rst,
  input  wgl_pkg::stn_ctl_t ctl,
  input  wgl_pkg::gain_t    gain,
  input  wgl_pkg::amp_t     cur_rdata,
  input  wgl_pkg::amp_t     old_rdata,
  output wgl_pkg::stn_out_t st
);
  import wgl_pkg::*;

  localparam logic signed [NEXT_W-1:0] NX_MAX = (NEXT_W'(1) <<< (AMP_W - 1)) - NEXT_W'(1);
  localparam logic signed [NEXT_W-1:0] NX_MIN = -(NEXT_W'(1) <<< (AMP_W - 1));

  // stage 1: memory data arrives
  stn_ctl_t s1_ctl;
  logic [AMP_W-1:0] lb1_rdata, lb2_rdata;
  amp_t y, z;
  amp_t ya, yb, za, xa;    // y(c-1), y(c-2), z(c-1), x(c-1)
  logic signed [LAP_W-1:0] lap_next;

  // stage 2
  logic s2_v, s2_w;
  logic signed [LAP_W-1:0] lap;
  amp_t ctr2, prev2;
  addr_t addr2;
  logic signed [GAIN_W:0] gain_s;

  // stage 3
  logic s3_v, s3_w;
  logic signed [PROD_W-1:0] prod, rnd, t;
  amp_t ctr3, prev3;
  addr_t addr3;
  logic signed [NEXT_W-1:0] nx;
  logic hi, lo;

  // lb1 holds row r-1, lb2 row r-2, indexed by column
  wgl_ram #(.ADDR_W(COORD_W), .DATA_W(AMP_W)) u_lb1 (
    .clk   (clk),
    .we    (s1_ctl.valid),
    .waddr (s1_ctl.col),
    .wdata (cur_rdata),
    .raddr (ctl.col),
    .rdata (lb1_rdata)
  );

  wgl_ram #(.ADDR_W(COORD_W), .DATA_W(AMP_W)) u_lb2 (
    .clk   (clk),
    .we    (s1_ctl.valid),
    .waddr (s1_ctl.col),
    .wdata (lb1_rdata),
    .raddr (ctl.col),
    .rdata (lb2_rdata)
  );

  assign y = lb1_rdata;
  assign z = lb2_rdata;

  // center ya, east y, west yb, north za, south xa
  assign lap_next = LAP_W'(y) + LAP_W'(yb) + LAP_W'(za) + LAP_W'(xa)
                  - (LAP_W'(ya) <<< 2);

  assign gain_s = {1'b0, gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_v   <= 1'b0;
      s2_w   <= 1'b0;
      s3_v   <= 1'b0;
      s3_w   <= 1'b0;
    end else begin
      s1_ctl <= ctl;
      s2_v   <= s1_ctl.valid;
      s2_w   <= s1_ctl.valid && s1_ctl.interior;
      s3_v   <= s2_v;
      s3_w   <= s2_w;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ctl.valid) begin
      ya    <= y;
      yb    <= ya;
      za    <= z;
      xa    <= cur_rdata;
      lap   <= lap_next;
      ctr2  <= ya;
      prev2 <= old_rdata;
      addr2 <= s1_ctl.ctr_addr;
    end
    prod  <= PROD_W'(lap) * PROD_W'(gain_s);
    ctr3  <= ctr2;
    prev3 <= prev2;
    addr3 <= addr2;
  end

  // round half up, then floor shift back to the amplitude scale
  assign rnd = prod + (PROD_W'(1) <<< (GAIN_FRAC - 1));
  assign t   = rnd >>> GAIN_FRAC;
  assign nx  = NEXT_W'(t) - NEXT_W'(prev3) + (NEXT_W'(ctr3) <<< 1);
  assign hi  = nx > NX_MAX;
  assign lo  = nx < NX_MIN;

  always_comb begin
    st.we   = s3_v && s3_w;
    st.addr = addr3;
    if (hi) begin
      st.data = amp_t'(NX_MAX);
    end else if (lo) begin
      st.data = amp_t'(NX_MIN);
    end else begin
      st.data = nx[AMP_W-1:0];
    end
    st.sat  = s3_v && s3_w && (hi || lo);
    st.busy = s1_ctl.valid || s2_v || s3_v;
  end

endmodule

@@ hdl/wave_grid_leapfrog_step.sv @@
// Top level of the 2D wave-equation leapfrog grid engine.
//
// Square-grid engine for the 2D wave equation (leapfrog finite differences).
// Two GRID_SIZE x GRID_SIZE banks of signed Q8.24 amplitudes hold the current
// and previous grids; the outer ring always reads zero. A request word
// carries cmd/row/col/value: write current cell, write previous cell, read
// current cell, or advance one step. Every request returns exactly one
// response word (amplitude for reads, saturation flag for steps, zero
// otherwise). A step streams the current bank once in raster order through
// two line buffers; each interior cell gets
//   next = round(k*(N+S+E+W-4C)) - prev + 2C, saturated to 32 bits,
// written over the previous bank, after which the banks swap roles.
// After reset a clearing pass zeroes both banks with req_ready low. A step
// reads one current-bank cell per cycle through the sweep, then drains the
// stencil before responding; a read waits for the registered RAM read.
// One request is in flight at a time; a response may sit in the output
// register while the next request is accepted. courant_gain (unsigned
// Q1.16, reset 30583) is written through gain_we/gain_wdata; the user must
// write it only while idle, and the block does not enforce this.
`include "wave_grid_leapfrog_step_defines.svh"

module wave_grid_leapfrog_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           gain_we,
  input  wgl_pkg::gain_t gain_wdata,
  input  logic           req_valid,
  output logic           req_ready,
  input  wgl_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output wgl_pkg::rsp_t  rsp
);
  import wgl_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,   // zeroing both banks after reset
    ST_IDLE,    // waiting for a request word
    ST_RDWAIT,  // RAM read latency for a cell read
    ST_SWEEP,   // streaming the grid into the stencil
    ST_DRAIN,   // stencil pipeline emptying
    ST_FINISH   // response waiting for the output register
  } state_t;

  state_t state;
  gain_t  gain;
  logic   bank_sel;      // 0: bank a is current
  addr_t  clr_cnt;
  addr_t  sw_addr;
  coord_t sw_row, sw_col;
  logic   rd_inside;
  amp_t   res_amp;
  logic   res_sat;
  logic   sat_acc;       // sticky saturation over one step

  // request decode
  logic  req_fire;
  addr_t req_addr;
  logic  req_int;

  // bank ports, by role
  logic  cur_we, old_we;
  addr_t cur_waddr, old_waddr, cur_raddr, old_raddr;
  amp_t  cur_wdata, old_wdata, cur_rdata, old_rdata;

  // bank ports, physical
  logic             a_we, b_we;
  addr_t            a_waddr, b_waddr, a_raddr, b_raddr;
  logic [AMP_W-1:0] a_wdata, b_wdata, a_rdata, b_rdata;
  logic             clearing;

  stn_ctl_t ctl;
  stn_out_t st;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign req_addr  = cell_addr(req.row, req.col);
  assign req_int   = is_interior(req.row, req.col);
  assign clearing  = (state == ST_CLEAR);

  // Sweep position -> stencil. The window centre lags the read by one row
  // and one column, so a centre is interior once row and col reach 2.
  always_comb begin
    ctl.valid    = (state == ST_SWEEP);
    ctl.col      = sw_col;
    ctl.ctr_addr = sw_addr - addr_t'(GRID_SIZE + 1);
    ctl.interior = (sw_row >= coord_t'(2)) && (sw_col >= coord_t'(2));
  end

  // Role-level port control: host writes go to either bank, sweep
  // write-back always lands in the previous bank.
  always_comb begin
    cur_we    = req_fire && (req.cmd == CMD_WR_CUR) && req_int;
    cur_waddr = req_addr;
    cur_wdata = req.value;
    cur_raddr = (state == ST_SWEEP) ? sw_addr : req_addr;

    old_we    = st.we || (req_fire && (req.cmd == CMD_WR_PREV) && req_int);
    old_waddr = st.we ? st.addr : req_addr;
    old_wdata = st.we ? st.data : req.value;
    old_raddr = ctl.ctr_addr;
  end

  // Map roles onto banks; the clearing pass overrides both write ports.
  always_comb begin
    a_we    = clearing || (bank_sel ? old_we : cur_we);
    a_waddr = clearing ? clr_cnt : (bank_sel ? old_waddr : cur_waddr);
    a_wdata = clearing ? '0 : (bank_sel ? old_wdata : cur_wdata);
    a_raddr = bank_sel ? old_raddr : cur_raddr;

    b_we    = clearing || (bank_sel ? cur_we : old_we);
    b_waddr = clearing ? clr_cnt : (bank_sel ? cur_waddr : old_waddr);
    b_wdata = clearing ? '0 : (bank_sel ? cur_wdata : old_wdata);
    b_raddr = bank_sel ? cur_raddr : old_raddr;

    cur_rdata = bank_sel ? b_rdata : a_rdata;
    old_rdata = bank_sel ? a_rdata : b_rdata;
  end

  wgl_ram #(.ADDR_W(ADDR_W), .DATA_W(AMP_W)) u_amp_bank_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  wgl_ram #(.ADDR_W(ADDR_W), .DATA_W(AMP_W)) u_amp_bank_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  wgl_stencil u_stencil (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .gain      (gain),
    .cur_rdata (cur_rdata),
    .old_rdata (old_rdata),
    .st        (st)
  );

  // Control FSM plus output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      gain      <= GAIN_RESET;
      bank_sel  <= 1'b0;
      clr_cnt   <= '0;
      sat_acc   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (gain_we) begin
        gain <= gain_wdata;
      end
      // in ST_FINISH the output register is reloaded below instead
      if (rsp_valid && rsp_ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      if (st.sat) begin
        sat_acc <= 1'b1;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + addr_t'(1);
          if (clr_cnt == addr_t'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            unique case (req.cmd) inside
              CMD_WR_CUR, CMD_WR_PREV: begin
                res_amp <= '0;
                res_sat <= 1'b0;
                state   <= ST_FINISH;
              end
              CMD_RD_CUR: begin
                rd_inside <= in_grid(req.row, req.col);
                state     <= ST_RDWAIT;
              end
              CMD_STEP: begin
                sw_addr <= '0;
                sw_row  <= '0;
                sw_col  <= '0;
                sat_acc <= 1'b0;
                state   <= ST_SWEEP;
              end
            endcase
          end
        end
        ST_RDWAIT: begin
          res_amp <= rd_inside ? cur_rdata : '0;
          res_sat <= 1'b0;
          state   <= ST_FINISH;
        end
        ST_SWEEP: begin
          if (sw_addr == addr_t'(CELLS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            sw_addr <= sw_addr + addr_t'(1);
            if (sw_col == coord_t'(GRID_SIZE - 1)) begin
              sw_col <= '0;
              sw_row <= sw_row + coord_t'(1);
            end else begin
              sw_col <= sw_col + coord_t'(1);
            end
          end
        end
        ST_DRAIN: begin
          // last write-back done: previous bank now holds the new grid
          if (!st.busy) begin
            bank_sel <= ~bank_sel;
            res_amp  <= '0;
            res_sat  <= sat_acc;
            state    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid     <= 1'b1;
            rsp.amplitude <= res_amp;
            rsp.saturated <= res_sat;
            state         <= ST_IDLE;
          end
        end
      endcase
    end
  end

  `WGL_ASSERT_IMP(a_no_wb_when_idle, clk, rst, req_ready, !st.we, "stencil write while idle")
  `WGL_ASSERT_IMP(a_sat_word_zero_amp, clk, rst, rsp_valid && rsp.saturated, rsp.amplitude == '0, "saturated word with amplitude")
  `WGL_ASSERT_IMP(a_swap_after_drain, clk, rst, bank_sel != $past(bank_sel), $past(state) == ST_DRAIN, "bank swap outside step end")
  `WGL_ASSERT_NEXT(a_drain_to_finish, clk, rst, state == ST_DRAIN && !st.busy, state == ST_FINISH, "drain did not finish")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the wave grid leapfrog step engine.
`timescale 1ns / 100ps

module testbench;
  import wgl_pkg::*;

  // Q1.16 gain settings used by the directed test and the random phases
  localparam gain_t GAIN_ZERO  = 17'h00000;
  localparam gain_t GAIN_HALF  = 17'h08000;  // stability limit
  localparam gain_t GAIN_UNITY = 17'h10000;  // top of the legal range

  localparam longint AMP_MAX = 64'sd2147483647;
  localparam longint AMP_MIN = -64'sd2147483648;

  // Receiver hold-off that backs the engine up into its request port
  localparam int LONG_HOLD_CYCLES = 400;

  // --------------------------------------------------------------------
  // Scoreboard: shadow copy of both amplitude banks plus the gain, and
  // the queue of response words the engine still owes us.
  // --------------------------------------------------------------------
  class leapfrog_scoreboard;
    bit signed [AMP_W-1:0] grid_bank [2][CELLS];
    bit                    cur_sel;
    gain_t                 gain;
    rsp_t                  awaited [$];
    int                    mismatches;

    function new();
      cur_sel    = 1'b0;
      gain       = GAIN_RESET;
      mismatches = 0;
    endfunction

    function void set_gain(gain_t g);
      gain = g;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // One leapfrog step over the interior, old values only; the new grid
    // lands in the previous bank, which then becomes current.
    function bit advance_grid();
      longint k, ctr, lap, scaled, nx;
      int     i;
      bit     nb;
      bit     clipped;
      k       = longint'(gain);
      nb      = ~cur_sel;
      clipped = 1'b0;
      for (int r = 1; r < GRID_SIZE - 1; r++) begin
        for (int q = 1; q < GRID_SIZE - 1; q++) begin
          i   = r * GRID_SIZE + q;
          ctr = grid_bank[cur_sel][i];
          lap = longint'(grid_bank[cur_sel][i - GRID_SIZE]) +
                longint'(grid_bank[cur_sel][i + GRID_SIZE]) +
                longint'(grid_bank[cur_sel][i - 1]) +
                longint'(grid_bank[cur_sel][i + 1]) - 4 * ctr;
          // round half up, floor shift back to amplitude scale
          scaled = (lap * k + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
          nx     = scaled - longint'(grid_bank[nb][i]) + 2 * ctr;
          if (nx > AMP_MAX) begin
            nx      = AMP_MAX;
            clipped = 1'b1;
          end
          if (nx < AMP_MIN) begin
            nx      = AMP_MIN;
            clipped = 1'b1;
          end
          grid_bank[nb][i] = nx[AMP_W-1:0];
        end
      end
      cur_sel = nb;
      return clipped;
    endfunction

    // Called for every accepted request word.
    function void note_request(req_t word);
      rsp_t want;
      int   idx;
      bit   on_interior;
      want        = '0;
      idx         = int'(word.row) * GRID_SIZE + int'(word.col);
      on_interior = (word.row >= 1) && (word.col >= 1) &&
                    (int'(word.row) < GRID_SIZE - 1) &&
                    (int'(word.col) < GRID_SIZE - 1);
      case (word.cmd)
        CMD_WR_CUR:  if (on_interior) grid_bank[cur_sel][idx] = word.value;
        CMD_WR_PREV: if (on_interior) grid_bank[~cur_sel][idx] = word.value;
        CMD_RD_CUR:  want.amplitude = grid_bank[cur_sel][idx];
        CMD_STEP:    want.saturated = advance_grid();
        default:     ;
      endcase
      awaited.push_back(want);
    endfunction

    // Called for every accepted response word.
    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        $error("unexpected response word: amplitude %0d saturated %0b",
               got.amplitude, got.saturated);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.amplitude !== want.amplitude) begin
        $error("amplitude: expected %0d, got %0d", want.amplitude, got.amplitude);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------
  logic  clk;
  logic  rst;
  logic  gain_we;
  gain_t gain_wdata;
  logic  req_valid;
  logic  req_ready;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_ready;
  rsp_t  rsp;

  wave_grid_leapfrog_step dut (
    .clk       (clk),
    .rst       (rst),
    .gain_we   (gain_we),
    .gain_wdata(gain_wdata),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  leapfrog_scoreboard board;

  bit idle_enabled     = 1'b1;  // random bubbles on both sides
  bit hold_off_request = 1'b0;  // ask the receiver for one long stall

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop, far past the slowest legal run (clear pass,
  // at most ten full-grid steps, every word stalled on both sides).
  initial begin
    #8_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------
  // Stimulus helpers. All driving happens at the falling edge; handshakes
  // are sampled at the rising edge, before the DUT's registers update.
  // --------------------------------------------------------------------
  function automatic req_t make_req(cmd_t cmd, logic [7:0] row, logic [7:0] col,
                                    amp_t value);
    req_t w;
    w.cmd   = cmd;
    w.row   = row;
    w.col   = col;
    w.value = value;
    return w;
  endfunction

  // Random word. Addresses mostly land in three small windows (top-left
  // corner, middle, bottom-right corner) so reads hit cells that were
  // written or that a step has touched; the rest roam the full grid.
  function automatic req_t random_request(inout int steps_left);
    req_t w;
    int   pick;
    int   base;
    w.row   = 8'($urandom);
    w.col   = 8'($urandom);
    w.value = amp_t'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 30)      w.cmd = CMD_WR_CUR;
    else if (pick < 50) w.cmd = CMD_WR_PREV;
    else if (pick < 88 || steps_left == 0) w.cmd = CMD_RD_CUR;
    else begin
      w.cmd = CMD_STEP;
      steps_left--;
    end
    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 2))
        0:       base = 0;
        1:       base = 121;
        default: base = 248;
      endcase
      w.row = 8'(base + $urandom_range(0, 7));
      w.col = 8'(base + $urandom_range(0, 7));
    end
    case ($urandom_range(0, 3))
      0: w.value = amp_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));  // +-1.0
      1: begin
        case ($urandom_range(0, 3))
          0:       w.value = 32'sh7FFFFFFF;
          1:       w.value = 32'sh80000000;
          2:       w.value = 32'sh00000000;
          default: w.value = 32'shFFFFFFFF;
        endcase
      end
      default: ;  // keep full-range random
    endcase
    return w;
  endfunction

  // Offer one word, hold it until accepted. Entered and left on a falling edge.
  task automatic send_request(req_t word);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    req       = word;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    board.note_request(word);
    @(negedge clk);
  endtask

  // Drop valid and wait for every owed response.
  task automatic drain_responses();
    req_valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Gain write, only while the engine is idle.
  task automatic load_gain(gain_t g);
    gain_we    = 1'b1;
    gain_wdata = g;
    @(negedge clk);
    gain_we = 1'b0;
    board.set_gain(g);
  endtask

  // --------------------------------------------------------------------
  // Response side: ready stretches broken by short random stalls, plus
  // one long hold-off on request.
  // --------------------------------------------------------------------
  initial begin
    bit held;
    held      = 1'b0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request && !held) begin
        held      = 1'b1;
        rsp_ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        rsp_ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      rsp_ready = 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_response(rsp);
  end

  // --------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------
  initial begin
    int steps_left;
    rst        = 1'b1;
    gain_we    = 1'b0;
    gain_wdata = '0;
    req_valid  = 1'b0;
    req        = '0;
    board      = new();

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // wait out the bank-clearing pass
    do @(posedge clk); while (!req_ready);
    @(negedge clk);

    // Directed: unity gain, both saturation directions, boundary writes
    // and reads, step with junk in the ignored fields.
    load_gain(GAIN_UNITY);
    send_request(make_req(CMD_WR_CUR,  8'd1,   8'd1,   32'sh7FFFFFFF));
    send_request(make_req(CMD_WR_PREV, 8'd1,   8'd1,   32'sh80000000));
    send_request(make_req(CMD_WR_CUR,  8'd254, 8'd254, 32'sh80000000));
    send_request(make_req(CMD_WR_PREV, 8'd254, 8'd254, 32'sh7FFFFFFF));
    send_request(make_req(CMD_WR_CUR,  8'd0,   8'd7,   32'sh12345678));  // ring
    send_request(make_req(CMD_WR_PREV, 8'd255, 8'd255, 32'sh7FFFFFFF));  // ring
    send_request(make_req(CMD_WR_CUR,  8'd9,   8'd255, 32'shEDCBA987));  // ring
    send_request(make_req(CMD_WR_CUR,  8'd128, 8'd128, 32'sh01000000));
    send_request(make_req(CMD_WR_PREV, 8'd128, 8'd128, 32'shFF000000));
    send_request(make_req(CMD_RD_CUR,  8'd0,   8'd7,   32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd1,   8'd1,   32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd254, 8'd254, 32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd128, 8'd128, 32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd255, 8'd0,   32'shFFFFFFFF));
    send_request(make_req(CMD_STEP,    8'd255, 8'd255, 32'shFFFFFFFF));
    send_request(make_req(CMD_RD_CUR,  8'd1,   8'd1,   32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd1,   8'd2,   32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd254, 8'd254, 32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd128, 8'd127, 32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd128, 8'd128, 32'sh0));
    send_request(make_req(CMD_STEP,    8'd0,   8'd0,   32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd128, 8'd129, 32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd127, 8'd128, 32'sh0));
    send_request(make_req(CMD_RD_CUR,  8'd2,   8'd2,   32'sh0));
    drain_responses();

    // Random phases, each with its own gain and at most two steps
    // (a step costs a full grid sweep). Phase 2 carries the long
    // receiver hold-off; the last phase runs with no bubbles at all.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       load_gain(GAIN_ZERO);
        1:       load_gain(gain_t'($urandom_range(1, 65535)));
        2:       load_gain(GAIN_RESET);
        default: load_gain(GAIN_HALF);
      endcase
      if (phase == 2) hold_off_request = 1'b1;
      if (phase == 3) idle_enabled = 1'b0;
      steps_left = 2;
      repeat (25) send_request(random_request(steps_left));
      drain_responses();
    end

    repeat (20) @(negedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
